FILE: design/stepper_relative_move_controller_macros.svh
// Assertion macros shared by the checker of the step/dir move controller.
`ifndef STEPPER_RELATIVE_MOVE_CONTROLLER_MACROS_SVH
`define STEPPER_RELATIVE_MOVE_CONTROLLER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SRMC_ASSERT_IMPLY(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
		else $error("implication check failed");

// Next-cycle implication, disabled during reset.
`define SRMC_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
		else $error("next-cycle check failed");

`endif

FILE: design/srmc_pkg.sv
// Shared types, codes and constants of the stepper relative move controller.
package srmc_pkg;

	localparam int TIMER_BITS_DEF = 16;
	localparam int DIV_W = 32;

	// Move phases
	localparam logic [1:0] PH_IDLE = 2'd0;
	localparam logic [1:0] PH_WAIT = 2'd1;
	localparam logic [1:0] PH_RUN  = 2'd2;

	// Register indexes
	localparam logic [2:0] REG_PPR     = 3'd0;
	localparam logic [2:0] REG_RPM     = 3'd1;
	localparam logic [2:0] REG_SETUP   = 3'd2;
	localparam logic [2:0] REG_TICK    = 3'd3;
	localparam logic [2:0] REG_DEG_MAX = 3'd4;
	localparam logic [2:0] REG_DEG_MIN = 3'd5;
	localparam logic [2:0] REG_CLK     = 3'd6;

	localparam logic [15:0] RATE_MAX     = 16'd50000;
	localparam logic [31:0] RATE_SAT_X   = 32'd48000000;
	localparam logic [15:0] DEG_LIMIT    = 16'd180;

	// Datapath commands
	localparam logic [3:0] CMD_NONE      = 4'd0;
	localparam logic [3:0] CMD_CAPTURE   = 4'd1;
	localparam logic [3:0] CMD_TICK      = 4'd2;
	localparam logic [3:0] CMD_RATE_MUL  = 4'd3;
	localparam logic [3:0] CMD_RATE_DIV  = 4'd4;
	localparam logic [3:0] CMD_RATE_SET  = 4'd5;
	localparam logic [3:0] CMD_TICKS_DIV = 4'd6;
	localparam logic [3:0] CMD_PSC       = 4'd7;
	localparam logic [3:0] CMD_LOAD      = 4'd8;
	localparam logic [3:0] CMD_PEND_MUL  = 4'd9;
	localparam logic [3:0] CMD_PEND_DIV  = 4'd10;
	localparam logic [3:0] CMD_PEND_SET  = 4'd11;
	localparam logic [3:0] CMD_DEG_PREP  = 4'd12;
	localparam logic [3:0] CMD_OUT       = 4'd13;

	typedef struct packed {
		logic [15:0]        ppr;
		logic [15:0]        rpm;
		logic [15:0]        setup_ms;
		logic [7:0]         tick_ms;
		logic signed [15:0] deg_max;
		logic signed [15:0] deg_min;
		logic [27:0]        clk_hz;
	} cfg_t;

	typedef struct packed {
		logic [3:0] op;
		logic       operation;
	} dp_cmd_t;

	typedef struct packed {
		logic div_done;
		logic wait_end;
		logic rate_zero;
		logic ticks_ok;
		logic pend_go;
		logic deg_sat;
	} dp_status_t;

endpackage

FILE: design/srmc_regs.sv
// APB configuration registers of the move controller.
module srmc_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [4:0]    paddr,
	input  logic [31:0]   pwdata,
	output logic [31:0]   prdata,
	output logic          pready,
	output srmc_pkg::cfg_t cfg
);
	import srmc_pkg::*;

	cfg_t        cfg_q;
	logic [2:0]  idx;

	assign idx    = paddr[4:2];
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.ppr      <= 16'd800;
			cfg_q.rpm      <= 16'd960;
			cfg_q.setup_ms <= 16'd5;
			cfg_q.tick_ms  <= 8'd1;
			cfg_q.deg_max  <= 16'sd2880;
			cfg_q.deg_min  <= -16'sd2880;
			cfg_q.clk_hz   <= 28'd72000000;
		end else if (psel && penable && pwrite) begin
			case (idx)
				REG_PPR:     cfg_q.ppr      <= pwdata[15:0];
				REG_RPM:     cfg_q.rpm      <= pwdata[15:0];
				REG_SETUP:   cfg_q.setup_ms <= pwdata[15:0];
				REG_TICK:    cfg_q.tick_ms  <= pwdata[7:0];
				REG_DEG_MAX: cfg_q.deg_max  <= pwdata[15:0];
				REG_DEG_MIN: cfg_q.deg_min  <= pwdata[15:0];
				REG_CLK:     cfg_q.clk_hz   <= pwdata[27:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			REG_PPR:     prdata = {16'd0, cfg_q.ppr};
			REG_RPM:     prdata = {16'd0, cfg_q.rpm};
			REG_SETUP:   prdata = {16'd0, cfg_q.setup_ms};
			REG_TICK:    prdata = {24'd0, cfg_q.tick_ms};
			REG_DEG_MAX: prdata = {{16{cfg_q.deg_max[15]}}, cfg_q.deg_max};
			REG_DEG_MIN: prdata = {{16{cfg_q.deg_min[15]}}, cfg_q.deg_min};
			REG_CLK:     prdata = {4'd0, cfg_q.clk_hz};
			default:     prdata = 32'd0;
		endcase
	end

endmodule

FILE: design/srmc_div.sv
// Restoring divider, one quotient bit per cycle.
module srmc_div #(
	parameter int W = srmc_pkg::DIV_W
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [W-1:0] num,
	input  logic [W-1:0] den,
	output logic [W-1:0] quo,
	output logic         done
);
	localparam int CW = $clog2(W + 1);
	localparam logic [CW-1:0] LAST = CW'(W - 1);

	logic          busy_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  quo_q;
	logic [W-1:0]  den_q;
	logic [W:0]    rem_q;
	logic [W:0]    rem_sh;
	logic          fits;

	assign rem_sh = {rem_q[W-1:0], quo_q[W-1]};
	assign fits   = rem_sh >= {1'b0, den_q};
	assign quo    = quo_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done   <= 1'b0;
		end else begin
			done <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done   <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[W-2:0], fits};
		end
	end

endmodule

FILE: design/srmc_datapath.sv
// Move state, timer arithmetic and result registers of the controller.
module srmc_datapath #(
	parameter int TIMER_BITS = srmc_pkg::TIMER_BITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  srmc_pkg::cfg_t         cfg,
	input  srmc_pkg::dp_cmd_t      cmd,
	output srmc_pkg::dp_status_t   status,
	input  logic signed [15:0]     target_deg_q4,
	input  logic [15:0]            timer_count,
	output logic                   busy_res,
	output logic                   direction_forward,
	output logic                   step_enable,
	output logic                   timer_load,
	output logic [15:0]            prescaler_value,
	output logic [15:0]            period_value,
	output logic [15:0]            compare_value,
	output logic [15:0]            step_rate_hz,
	output logic signed [31:0]     position_steps,
	output logic signed [8:0]      logical_deg
);
	import srmc_pkg::*;

	localparam int FULL_W = TIMER_BITS + 1;
	localparam int SUM_W  = (TIMER_BITS > 28 ? TIMER_BITS : 28) + 1;
	localparam int ARR_W  = (FULL_W > DIV_W ? FULL_W : DIV_W);
	localparam logic [FULL_W-1:0] FULL = FULL_W'(1) << TIMER_BITS;
	// reciprocals for the constant divides: /960 = >>6 then /15, /5760 = >>7 then /45
	localparam logic [24:0] RCP_15 = 25'd17895698;   // ceil(2^28 / 15)
	localparam logic [25:0] RCP_45 = 26'd47721859;   // ceil(2^31 / 45)

	// architectural state
	logic [1:0]         phase_q;
	logic [31:0]        total_q, done_q, pos_q;
	logic               fwd_q, pend_q, dir_q, chan_q, loaded_q;
	logic [15:0]        wait_q, last_q, count_q, rate_q;
	logic signed [15:0] pang_q;
	logic [15:0]        psc_reg_q, per_q, cmp_q;
	// scratch
	logic [31:0]        x_q, prod_q;
	logic [15:0]        rq_q;
	logic [31:0]        pq_q;
	logic [SUM_W-1:0]   psc_q;
	logic               pfwd_q, deg_sat_q;

	// divider
	logic               div_start, div_done;
	logic [DIV_W-1:0]   div_num, div_den, q;

	srmc_div #(.W(DIV_W)) u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start),
		.num(div_num), .den(div_den), .quo(q), .done(div_done)
	);

	// tick arithmetic
	logic [15:0]        wait_next;
	logic               wrap;
	logic [31:0]        done_inc;
	logic [15:0]        rate_next;
	logic [19:0]        rate_m;
	logic [44:0]        rate_prod;
	logic [24:0]        pend_m;
	logic [50:0]        pend_prod;
	logic [SUM_W-1:0]   psc_sum, psc_raw, psc_c;
	logic [ARR_W-1:0]   arr_c;
	logic [15:0]        pmag, d;
	logic [31:0]        mag;
	logic               neg, sat;
	logic [24:0]        deg_prod;
	logic signed [15:0] clamped;
	logic [8:0]         r9;

	always_comb begin
		wait_next = (wait_q > {8'd0, cfg.tick_ms}) ? wait_q - {8'd0, cfg.tick_ms} : 16'd0;
		wrap      = count_q < last_q;
		done_inc  = done_q + {31'd0, wrap};
		rate_m    = 20'((x_q + 32'd480) >> 6);
		rate_prod = 45'(rate_m) * 45'(RCP_15);
		pend_m    = 25'((prod_q + 32'd2880) >> 7);
		pend_prod = 51'(pend_m) * 51'(RCP_45);
		if (cfg.rpm == 16'd0)
			rate_next = 16'd0;
		else if (x_q >= RATE_SAT_X)
			rate_next = RATE_MAX;
		else
			rate_next = rq_q;
		psc_sum = SUM_W'(q[27:0]) + SUM_W'(FULL) - SUM_W'(1);
		psc_raw = psc_sum >> TIMER_BITS;
		if (psc_raw == '0)
			psc_c = SUM_W'(1);
		else if (psc_raw > SUM_W'(FULL))
			psc_c = SUM_W'(FULL);
		else
			psc_c = psc_raw;
		if (ARR_W'(q) < ARR_W'(2))
			arr_c = ARR_W'(2);
		else if (ARR_W'(q) > ARR_W'(FULL))
			arr_c = ARR_W'(FULL);
		else
			arr_c = ARR_W'(q);
		pmag = pang_q[15] ? 16'(-pang_q) : 16'(pang_q);
		d    = (cfg.ppr == 16'd0) ? 16'd1 : cfg.ppr;
		neg  = pos_q[31];
		mag  = neg ? 32'd0 - pos_q : pos_q;
		sat  = {mag, 1'b0} >= 33'(d);
		deg_prod = 25'(mag[14:0]) * 25'd720;
		if (target_deg_q4 > cfg.deg_max)
			clamped = cfg.deg_max;
		else if (target_deg_q4 < cfg.deg_min)
			clamped = cfg.deg_min;
		else
			clamped = target_deg_q4;
		r9 = deg_sat_q ? DEG_LIMIT[8:0] : q[8:0];
	end

	always_comb begin
		div_start = 1'b0;
		div_num   = '0;
		div_den   = '0;
		case (cmd.op)
			CMD_TICKS_DIV: begin
				div_start = 1'b1;
				div_num   = {4'd0, cfg.clk_hz};
				div_den   = {16'd0, rate_q};
			end
			CMD_PSC: begin
				div_start = q >= 32'd2;
				div_num   = q + 32'(psc_c) - 32'd1;
				div_den   = 32'(psc_c);
			end
			CMD_DEG_PREP: begin
				div_start = !sat;
				div_num   = 32'(deg_prod) + 32'(d);
				div_den   = {15'd0, d, 1'b0};
			end
			default: ;
		endcase
	end

	assign status.div_done  = div_done;
	assign status.wait_end  = (phase_q == PH_WAIT) && (wait_next == 16'd0);
	assign status.rate_zero = rate_next == 16'd0;
	assign status.ticks_ok  = q >= 32'd2;
	assign status.pend_go   = pend_q && phase_q != PH_RUN && phase_q != PH_WAIT;
	assign status.deg_sat   = sat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			total_q   <= '0;
			done_q    <= '0;
			fwd_q     <= 1'b0;
			wait_q    <= '0;
			last_q    <= '0;
			pos_q     <= '0;
			pend_q    <= 1'b0;
			pang_q    <= '0;
			rate_q    <= '0;
			dir_q     <= 1'b1;
			chan_q    <= 1'b0;
			psc_reg_q <= 16'd0;
			per_q     <= 16'd65535;
			cmp_q     <= 16'd1;
			loaded_q  <= 1'b0;
		end else begin
			case (cmd.op)
				CMD_CAPTURE: begin
					loaded_q <= 1'b0;
					if (cmd.operation && clamped != 16'sd0) begin
						pang_q <= clamped;
						pend_q <= 1'b1;
					end
				end
				CMD_TICK: begin
					if (phase_q == PH_RUN) begin
						last_q <= count_q;
						if (wrap) pos_q <= fwd_q ? pos_q + 32'd1 : pos_q - 32'd1;
						if (done_inc >= total_q) begin
							// all pulses out: stop the move
							rate_q  <= '0;
							chan_q  <= 1'b0;
							phase_q <= PH_IDLE;
							done_q  <= '0;
							total_q <= '0;
						end else begin
							done_q <= done_inc;
						end
					end else if (phase_q == PH_WAIT) begin
						wait_q <= wait_next;
					end
				end
				CMD_RATE_SET: begin
					rate_q <= rate_next;
					if (rate_next == 16'd0) begin
						chan_q  <= 1'b0;
						phase_q <= PH_IDLE;
						done_q  <= '0;
						total_q <= '0;
					end
				end
				CMD_PSC: begin
					if (q < 32'd2) begin
						// too fast for the timer: run without a reload
						last_q  <= count_q;
						phase_q <= PH_RUN;
					end
				end
				CMD_LOAD: begin
					psc_reg_q <= 16'(psc_q - SUM_W'(1));
					per_q     <= 16'(arr_c - ARR_W'(1));
					cmp_q     <= 16'((arr_c + ARR_W'(1)) >> 1);
					chan_q    <= 1'b1;
					loaded_q  <= 1'b1;
					last_q    <= '0;
					phase_q   <= PH_RUN;
				end
				CMD_PEND_MUL: begin
					if (status.pend_go) begin
						pend_q <= 1'b0;
						pang_q <= '0;
					end
				end
				CMD_PEND_SET: begin
					if (pq_q != 32'd0) begin
						fwd_q   <= pfwd_q;
						dir_q   <= pfwd_q;
						total_q <= pq_q;
						done_q  <= '0;
						wait_q  <= cfg.setup_ms;
						phase_q <= PH_WAIT;
					end
				end
				default: ;
			endcase
		end
	end

	// scratch and result registers
	always_ff @(posedge clk) begin
		case (cmd.op)
			CMD_CAPTURE:  count_q <= timer_count;
			CMD_RATE_MUL: x_q     <= 32'(cfg.rpm) * 32'(cfg.ppr);
			CMD_RATE_DIV: rq_q    <= rate_prod[43:28];
			CMD_PSC:      psc_q   <= psc_c;
			CMD_PEND_MUL: begin
				prod_q <= 32'(pmag) * 32'(cfg.ppr);
				pfwd_q <= !pang_q[15];
			end
			CMD_PEND_DIV: pq_q    <= 32'(pend_prod[50:31]);
			CMD_DEG_PREP: deg_sat_q <= sat;
			CMD_OUT: begin
				busy_res          <= phase_q == PH_WAIT || phase_q == PH_RUN;
				direction_forward <= dir_q;
				step_enable       <= chan_q;
				timer_load        <= loaded_q;
				prescaler_value   <= psc_reg_q;
				period_value      <= per_q;
				compare_value     <= cmp_q;
				step_rate_hz      <= rate_q;
				position_steps    <= pos_q;
				logical_deg       <= neg ? 9'd0 - r9 : r9;
			end
			default: ;
		endcase
	end

endmodule

FILE: design/srmc_ctrl.sv
// Sequencer for one item of the move controller.
module srmc_ctrl (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  logic                  operation,
	output logic                  out_valid,
	input  logic                  out_ready,
	output srmc_pkg::dp_cmd_t     cmd,
	input  srmc_pkg::dp_status_t  status
);
	import srmc_pkg::*;

	localparam logic [3:0] C_IDLE  = 4'd0;
	localparam logic [3:0] C_TICK  = 4'd1;
	localparam logic [3:0] C_RMUL  = 4'd2;
	localparam logic [3:0] C_RDIV  = 4'd3;
	localparam logic [3:0] C_RSET  = 4'd5;
	localparam logic [3:0] C_TDIV  = 4'd6;
	localparam logic [3:0] C_TWAIT = 4'd7;
	localparam logic [3:0] C_PSC   = 4'd8;
	localparam logic [3:0] C_AWAIT = 4'd9;
	localparam logic [3:0] C_LOAD  = 4'd10;
	localparam logic [3:0] C_PMUL  = 4'd11;
	localparam logic [3:0] C_PDIV  = 4'd12;
	localparam logic [3:0] C_PSET  = 4'd14;
	localparam logic [3:0] C_DEG   = 4'd15;

	logic [3:0] st_q, st_d;
	logic       deg_wait_q, deg_wait_d;
	logic       out_free;
	// divide in flight for the angle step
	logic       busy_div_q;

	assign in_ready      = st_q == C_IDLE;
	assign out_free      = !out_valid || out_ready;

	// C_DEG runs in two steps: prepare (and maybe divide), then write the result
	always_comb begin
		st_d          = st_q;
		deg_wait_d    = deg_wait_q;
		cmd.op        = CMD_NONE;
		cmd.operation = operation;
		case (st_q)
			C_IDLE: if (in_valid) begin
				cmd.op     = CMD_CAPTURE;
				deg_wait_d = 1'b0;
				st_d       = operation ? C_DEG : C_TICK;
			end
			C_TICK: begin
				cmd.op = CMD_TICK;
				st_d   = status.wait_end ? C_RMUL : C_PMUL;
			end
			C_RMUL: begin cmd.op = CMD_RATE_MUL; st_d = C_RDIV; end
			C_RDIV: begin cmd.op = CMD_RATE_DIV; st_d = C_RSET; end
			C_RSET: begin
				cmd.op = CMD_RATE_SET;
				st_d   = status.rate_zero ? C_PMUL : C_TDIV;
			end
			C_TDIV: begin cmd.op = CMD_TICKS_DIV; st_d = C_TWAIT; end
			C_TWAIT: if (status.div_done) st_d = C_PSC;
			C_PSC: begin
				cmd.op = CMD_PSC;
				st_d   = status.ticks_ok ? C_AWAIT : C_PMUL;
			end
			C_AWAIT: if (status.div_done) st_d = C_LOAD;
			C_LOAD: begin cmd.op = CMD_LOAD; st_d = C_PMUL; end
			C_PMUL: begin
				cmd.op = CMD_PEND_MUL;
				st_d   = status.pend_go ? C_PDIV : C_DEG;
			end
			C_PDIV: begin cmd.op = CMD_PEND_DIV; st_d = C_PSET; end
			C_PSET: begin cmd.op = CMD_PEND_SET; st_d = C_DEG; end
			C_DEG: begin
				if (!deg_wait_q) begin
					cmd.op     = CMD_DEG_PREP;
					deg_wait_d = 1'b1;
					// saturated angle needs no divide: the prep step is taken either way
				end else if ((status.div_done || !busy_div_q) && out_free) begin
					cmd.op = CMD_OUT;
					st_d   = C_IDLE;
				end
			end
			default: st_d = C_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q       <= C_IDLE;
			deg_wait_q <= 1'b0;
			busy_div_q <= 1'b0;
			out_valid  <= 1'b0;
		end else begin
			st_q       <= st_d;
			deg_wait_q <= deg_wait_d;
			if (cmd.op == CMD_DEG_PREP)
				busy_div_q <= !status.deg_sat;
			else if (status.div_done)
				busy_div_q <= 1'b0;
			if (cmd.op == CMD_OUT)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
		end
	end

endmodule

FILE: design/stepper_relative_move_controller.sv
// Top level of the stepper relative move controller.
// Accept to result valid: a set-target item at a saturated angle needs no divider pass, else
// one divider pass for degrees; a tick that starts the step clock takes up to three passes
// (timer ticks, auto-reload, degrees). One item is in flight at a time; in_ready returns
// in the same cycle as out_valid, once the result is registered.
// Reset (arst_n low, asynchronous): idle, no pending target, direction forward, timer 0/65535/1.
module stepper_relative_move_controller #(
	parameter int TIMER_BITS = srmc_pkg::TIMER_BITS_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic               operation,
	input  logic signed [15:0] target_deg_q4,
	input  logic [15:0]        timer_count,
	output logic               out_valid,
	input  logic               out_ready,
	output logic               busy_res,
	output logic               direction_forward,
	output logic               step_enable,
	output logic               timer_load,
	output logic [15:0]        prescaler_value,
	output logic [15:0]        period_value,
	output logic [15:0]        compare_value,
	output logic [15:0]        step_rate_hz,
	output logic signed [31:0] position_steps,
	output logic signed [8:0]  logical_deg,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [4:0]         paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);
	import srmc_pkg::*;

	cfg_t       cfg;
	dp_cmd_t    cmd;
	dp_status_t status;

	// configuration registers; the user must write them only while no item is in flight, the block does not enforce it
	srmc_regs u_regs (
		.clk(clk), .arst_n(arst_n), .psel(psel), .penable(penable), .pwrite(pwrite),
		.paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
	);

	// sequencer: accept one item, step the datapath, hold the result until taken
	srmc_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_ready(in_ready),
		.operation(operation), .out_valid(out_valid), .out_ready(out_ready),
		.cmd(cmd), .status(status)
	);

	// move state, timer math over the shared divider, result registers
	srmc_datapath #(.TIMER_BITS(TIMER_BITS)) u_dp (
		.clk(clk), .arst_n(arst_n), .cfg(cfg), .cmd(cmd), .status(status),
		.target_deg_q4(target_deg_q4), .timer_count(timer_count),
		.busy_res(busy_res), .direction_forward(direction_forward),
		.step_enable(step_enable), .timer_load(timer_load),
		.prescaler_value(prescaler_value), .period_value(period_value),
		.compare_value(compare_value), .step_rate_hz(step_rate_hz),
		.position_steps(position_steps), .logical_deg(logical_deg)
	);

endmodule

FILE: design/srmc_checker.sv
// Port-level checker of the move controller and its bind.
`include "stepper_relative_move_controller_macros.svh"

module srmc_props (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        step_enable,
	input logic        timer_load,
	input logic [15:0] step_rate_hz
);
	// hold a result that was not taken
	`SRMC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid)
	// one item at a time: no accept right after an accept
	`SRMC_ASSERT_NEXT(a_one_item, clk, arst_n, in_valid && in_ready, !in_ready)
	// a waiting result keeps its payload
	`SRMC_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && !out_ready, $stable({step_enable, timer_load, step_rate_hz}))
	// a timer load always enables the step channel
	`SRMC_ASSERT_IMPLY(a_load_en, clk, arst_n, out_valid && timer_load, step_enable)
	// the step rate never passes its ceiling
	`SRMC_ASSERT_IMPLY(a_rate_max, clk, arst_n, out_valid, step_rate_hz <= 16'd50000)
endmodule

bind stepper_relative_move_controller srmc_props u_srmc_props (.*);
